// ----- rtl/core/lsms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsms_pkg
// Shared field widths, register map, reset values and the scan phase type
// for the lamp and switch matrix scanner.
// ----------------------------------------------------------------------------
package lsms_pkg;

   // request and response field widths
   localparam int COLUMN_W     = 12;
   localparam int LAMP_ROW_W   = 3;
   localparam int LAMP_SEL_W   = 8;
   localparam int SWITCH_SEL_W = 3;
   localparam int CHG_ROW_W    = 2;
   localparam int BLINK_W      = 6;
   localparam int TICK_W       = 16;

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // register reset values
   localparam logic [TICK_W-1:0] LAMP_DWELL_RESET    = 16'd325;
   localparam logic [TICK_W-1:0] SWITCH_SETTLE_RESET = 16'd3;

   // request modes
   localparam logic MODE_TICK       = 1'b0;
   localparam logic MODE_LAMP_WRITE = 1'b1;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      CSR_SCAN_ENABLE   = 2'd0,
      CSR_LAMP_DWELL    = 2'd1,
      CSR_SWITCH_SETTLE = 2'd2,
      CSR_REPORT_ENABLE = 2'd3
   } csr_index_type;

   // frame sequencer phases
   typedef enum logic [2:0] {
      PH_LAMP_ON  = 3'b001,
      PH_LAMP_OFF = 3'b010,
      PH_SWITCH   = 3'b100
   } phase_type;

endpackage

// ----- rtl/core/lsms_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsms_req_if
// Request channel: one clock tick with column senses, or a lamp row write.
// ----------------------------------------------------------------------------
interface lsms_req_if
   import lsms_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [COLUMN_W-1:0]   column_sense;
   logic [LAMP_ROW_W-1:0] lamp_row;
   logic [COLUMN_W-1:0]   lamp_word;

   modport source (
      output valid, mode, column_sense, lamp_row, lamp_word,
      input  ready
   );

   modport sink (
      input  valid, mode, column_sense, lamp_row, lamp_word,
      output ready
   );
endinterface

// ----- rtl/core/lsms_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsms_rsp_if
// Response channel: drive levels for one tick plus an optional change report.
// ----------------------------------------------------------------------------
interface lsms_rsp_if
   import lsms_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [COLUMN_W-1:0]     column_drive;
   logic                    column_drive_enable;
   logic [LAMP_SEL_W-1:0]   lamp_row_select;
   logic [SWITCH_SEL_W-1:0] switch_row_select;
   logic                    change_valid;
   logic [CHG_ROW_W-1:0]    change_row;
   logic [COLUMN_W-1:0]     change_value;
   logic [BLINK_W-1:0]      blink_phase;

   modport source (
      output valid, column_drive, column_drive_enable, lamp_row_select,
             switch_row_select, change_valid, change_row, change_value,
             blink_phase,
      input  ready
   );

   modport sink (
      input  valid, column_drive, column_drive_enable, lamp_row_select,
             switch_row_select, change_valid, change_row, change_value,
             blink_phase,
      output ready
   );
endinterface

// ----- rtl/core/led_switch_matrix_scanner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_switch_matrix_scanner
// Multiplexed lamp and switch matrix scanner. Each request is one clock tick
// carrying the sampled column levels, or a lamp row write. Every request gives
// exactly one response with the row selects and column drive for that tick,
// a switch change report when a sampled switch row changed and reports are
// enabled, and the blink phase (frame count modulo 64).
// Response: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while the response register is not held
// by backpressure; the sequencer step is a single pass of counter compare and
// row select logic between the state registers and the response register.
// Backpressure: the response register holds while rsp_chan.ready is low;
// a new request is taken whenever that register is empty or being drained.
// Reset: lamp and switch words clear, the sequencer restarts at lamp row 0
// on-phase, scanning is enabled, dwell 325 ticks, settle 3 ticks, change
// reports off. Registers sit on an APB-style port at byte address 4*index.
// ----------------------------------------------------------------------------
module led_switch_matrix_scanner
   import lsms_pkg::*;
#(
   parameter int LAMP_ROWS   = 8,
   parameter int SWITCH_ROWS = 3,
   parameter int COLUMNS     = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   lsms_req_if.sink              req_chan,
   lsms_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // stored word width and row counter widths
   localparam int LCOL    = (COLUMNS < COLUMN_W) ? COLUMNS : COLUMN_W;
   localparam int MAXROWS = (LAMP_ROWS > SWITCH_ROWS) ? LAMP_ROWS : SWITCH_ROWS;
   localparam int ROW_W   = (MAXROWS > 1) ? $clog2(MAXROWS) : 1;
   localparam int LIDX_W  = (LAMP_ROWS > 1) ? $clog2(LAMP_ROWS) : 1;
   localparam int SIDX_W  = (SWITCH_ROWS > 1) ? $clog2(SWITCH_ROWS) : 1;
   localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);

   // configuration registers
   logic              scan_enable_ff;
   logic [TICK_W-1:0] lamp_dwell_ff;
   logic [TICK_W-1:0] switch_settle_ff;
   logic              report_enable_ff;
   logic              csr_write;
   csr_index_type     csr_index;

   // sequencer state
   logic [LCOL-1:0]    lamp_words_ff   [LAMP_ROWS];
   logic [LCOL-1:0]    switch_words_ff [SWITCH_ROWS];
   phase_type          phase_ff, phase_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [BLINK_W-1:0] frame_ff, frame_in;

   // response register
   logic                    rsp_valid_ff;
   logic [COLUMN_W-1:0]     column_drive_ff, column_drive_in;
   logic                    drive_enable_ff, drive_enable_in;
   logic [LAMP_SEL_W-1:0]   lamp_sel_ff, lamp_sel_in;
   logic [SWITCH_SEL_W-1:0] switch_sel_ff, switch_sel_in;
   logic                    change_valid_ff, change_valid_in;
   logic [CHG_ROW_W-1:0]    change_row_ff, change_row_in;
   logic [COLUMN_W-1:0]     change_value_ff, change_value_in;

   // request side helpers
   logic              req_take;
   logic              lamp_write;
   logic [15:0]       lamp_row_ext;
   logic [LIDX_W-1:0] lamp_wr_idx;
   logic [LIDX_W-1:0] lamp_rd_idx;
   logic [SIDX_W-1:0] switch_idx;
   logic [LCOL-1:0]   lamp_wr_word;
   logic [LCOL-1:0]   lamp_cur_word;
   logic [LCOL-1:0]   scan_word;
   logic [TICK_W:0]   tick_done;
   logic              switch_sample;

   // ------------------------------------------------------------------------
   // configuration port
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_enable_ff   <= 1'b1;
         lamp_dwell_ff    <= LAMP_DWELL_RESET;
         switch_settle_ff <= SWITCH_SETTLE_RESET;
         report_enable_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCAN_ENABLE:   scan_enable_ff   <= pwdata[0];
            CSR_LAMP_DWELL:    lamp_dwell_ff    <= pwdata[TICK_W-1:0];
            CSR_SWITCH_SETTLE: switch_settle_ff <= pwdata[TICK_W-1:0];
            CSR_REPORT_ENABLE: report_enable_ff <= pwdata[0];
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_index)
         CSR_SCAN_ENABLE:   prdata = CSR_DATA_W'(scan_enable_ff);
         CSR_LAMP_DWELL:    prdata = CSR_DATA_W'(lamp_dwell_ff);
         CSR_SWITCH_SETTLE: prdata = CSR_DATA_W'(switch_settle_ff);
         CSR_REPORT_ENABLE: prdata = CSR_DATA_W'(report_enable_ff);
      endcase
   end

   // ------------------------------------------------------------------------
   // handshake: take a request when the response register is free
   // ------------------------------------------------------------------------
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   // lamp write decode, rows past the lamp count are dropped
   assign lamp_row_ext = 16'(req_chan.lamp_row);
   assign lamp_wr_idx  = lamp_row_ext[LIDX_W-1:0];
   assign lamp_wr_word = req_chan.lamp_word[LCOL-1:0];
   assign lamp_write   = (req_chan.mode == MODE_LAMP_WRITE)
                         && (int'(req_chan.lamp_row) < LAMP_ROWS);

   // current row words, with the same-cycle lamp write forwarded
   assign lamp_rd_idx   = row_ff[LIDX_W-1:0];
   assign switch_idx    = row_ff[SIDX_W-1:0];
   assign scan_word     = req_chan.column_sense[LCOL-1:0];
   assign lamp_cur_word = (lamp_write && (int'(req_chan.lamp_row) == int'(row_ff)))
                          ? lamp_wr_word : lamp_words_ff[lamp_rd_idx];

   assign tick_done = {1'b0, tick_ff} + (TICK_W+1)'(1);

   // ------------------------------------------------------------------------
   // sequencer step and response values
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in        = phase_ff;
      row_in          = row_ff;
      tick_in         = tick_ff;
      frame_in        = frame_ff;
      column_drive_in = '0;
      drive_enable_in = 1'b0;
      lamp_sel_in     = '0;
      switch_sel_in   = '0;
      change_valid_in = 1'b0;
      change_row_in   = '0;
      change_value_in = '0;
      switch_sample   = 1'b0;

      // frame start bumps the blink counter before the drive is shown
      if (req_chan.mode == MODE_TICK && scan_enable_ff && phase_ff == PH_LAMP_ON
          && row_ff == '0 && tick_ff == '0) begin
         frame_in = frame_ff + BLINK_W'(1);
      end

      // drive levels for this tick
      if (scan_enable_ff) begin
         if (phase_ff == PH_SWITCH) begin
            for (int i = 0; i < SWITCH_SEL_W; i++) begin
               switch_sel_in[i] = (int'(row_ff) == i);
            end
         end else begin
            column_drive_in = COLUMN_W'(~lamp_cur_word);
            drive_enable_in = 1'b1;
            if (phase_ff == PH_LAMP_ON) begin
               for (int i = 0; i < LAMP_SEL_W; i++) begin
                  lamp_sel_in[i] = (int'(row_ff) == i);
               end
            end
         end
      end

      // advance the sequencer on an enabled tick
      if (req_chan.mode == MODE_TICK && scan_enable_ff) begin
         tick_in = tick_done[TICK_W-1:0];
         unique case (phase_ff)
            PH_LAMP_ON: begin
               if (tick_done >= {1'b0, lamp_dwell_ff}) begin
                  tick_in  = '0;
                  phase_in = PH_LAMP_OFF;
               end
            end
            PH_LAMP_OFF: begin
               if (tick_done >= {1'b0, lamp_dwell_ff}) begin
                  tick_in = '0;
                  if (int'(row_ff) + 1 >= LAMP_ROWS) begin
                     row_in   = '0;
                     phase_in = PH_SWITCH;
                  end else begin
                     row_in   = row_ff + ROW_ONE;
                     phase_in = PH_LAMP_ON;
                  end
               end
            end
            PH_SWITCH: begin
               if (tick_done >= {1'b0, switch_settle_ff}) begin
                  switch_sample = 1'b1;
                  tick_in       = '0;
                  if (scan_word != switch_words_ff[switch_idx] && report_enable_ff) begin
                     change_valid_in = 1'b1;
                     change_row_in   = CHG_ROW_W'(row_ff);
                     change_value_in = COLUMN_W'(scan_word);
                  end
                  if (int'(row_ff) + 1 >= SWITCH_ROWS) begin
                     row_in   = '0;
                     phase_in = PH_LAMP_ON;
                  end else begin
                     row_in = row_ff + ROW_ONE;
                  end
               end
            end
            default: begin
               phase_in = PH_LAMP_ON;
               row_in   = '0;
               tick_in  = '0;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // state registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LAMP_ON;
         row_ff   <= '0;
         tick_ff  <= '0;
         frame_ff <= '0;
         for (int i = 0; i < LAMP_ROWS; i++) begin
            lamp_words_ff[i] <= '0;
         end
         for (int i = 0; i < SWITCH_ROWS; i++) begin
            switch_words_ff[i] <= '0;
         end
      end else if (req_take) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         tick_ff  <= tick_in;
         frame_ff <= frame_in;
         if (lamp_write) begin
            lamp_words_ff[lamp_wr_idx] <= lamp_wr_word;
         end
         if (switch_sample) begin
            switch_words_ff[switch_idx] <= scan_word;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         column_drive_ff <= column_drive_in;
         drive_enable_ff <= drive_enable_in;
         lamp_sel_ff     <= lamp_sel_in;
         switch_sel_ff   <= switch_sel_in;
         change_valid_ff <= change_valid_in;
         change_row_ff   <= change_row_in;
         change_value_ff <= change_value_in;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.column_drive        = column_drive_ff;
   assign rsp_chan.column_drive_enable = drive_enable_ff;
   assign rsp_chan.lamp_row_select     = lamp_sel_ff;
   assign rsp_chan.switch_row_select   = switch_sel_ff;
   assign rsp_chan.change_valid        = change_valid_ff;
   assign rsp_chan.change_row          = change_row_ff;
   assign rsp_chan.change_value        = change_value_ff;
   assign rsp_chan.blink_phase         = frame_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a lamp row and a switch row are never selected together
   a_sel_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !((|lamp_sel_ff) && (|switch_sel_ff)))
      else $error("lamp and switch rows selected together");

   // at most one lamp row lit at a time
   a_lamp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(lamp_sel_ff))
      else $error("more than one lamp row selected");

   // a change report only comes from a switch phase tick
   a_change_in_switch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && change_valid_ff) |-> (switch_sel_ff != '0 && !drive_enable_ff))
      else $error("change report outside a switch row");

   // a taken request always yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("request taken without a response");

endmodule
